// ----- rtl/rtmbp_pkg.sv -----
// Package with the shared types and constants of the monochrome raster packer.
package rtmbp_pkg;

    localparam int MAX_WIDTH = 4096;

    localparam int WIDTH_W = 13;
    localparam int BPP_W   = 7;
    localparam int CFG_W   = 13;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_PIXELS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BITS_PER_PIXEL = 1'b1;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 13'd1;
    localparam logic [BPP_W-1:0]   BPP_RESET   = 7'd8;

    typedef enum logic [1:0] {
        MODE_ONE_BIT,
        MODE_WIDE,
        MODE_WHITE
    } mode_t;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       line_end;
    } result_t;

endpackage

// ----- rtl/rtmbp_in_reg.sv -----
// Input register that holds one raster byte until the packing core takes it.
module rtmbp_in_reg (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] raw_byte,
    input  logic       advance,
    output logic       in_stall,
    output logic       item_valid,
    output logic [7:0] item_byte
);
    import rtmbp_pkg::*;

    logic       valid_reg;
    logic [7:0] byte_reg;

    assign in_stall   = valid_reg && !advance;
    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            byte_reg <= raw_byte;
        end
    end

endmodule

// ----- rtl/rtmbp_pack_core.sv -----
// Configuration registers, line state and the per-byte pixel conversion and packing logic.
module rtmbp_pack_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rtmbp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rtmbp_pkg::CFG_W-1:0]     cfg_data,
    input  logic                            item_valid,
    input  logic [7:0]                      item_byte,
    input  logic                            advance,
    output logic                            res_valid,
    output rtmbp_pkg::result_t              res
);
    import rtmbp_pkg::*;

    localparam logic [13:0] MAX_W = 14'(MAX_WIDTH);

    logic [WIDTH_W-1:0] width_pixels_reg;
    logic [BPP_W-1:0]   bits_per_pixel_reg;

    logic [12:0] pixel_column_reg, pixel_column_next;
    logic [2:0]  byte_in_pixel_reg, byte_in_pixel_next;
    logic [17:0] weighted_sum_reg, weighted_sum_next;
    logic [7:0]  pack_shift_reg, pack_shift_next;

    logic [13:0] eff_w;
    logic [6:0]  bpp;
    mode_t       mode;
    logic [13:0] rem_px;
    logic [3:0]  n_bytes;
    logic [9:0]  weight;
    logic [17:0] sum;
    logic [3:0]  idx_inc;
    logic [17:0] thresh;
    logic        black;
    logic [7:0]  pack_new;
    logic [13:0] col;
    logic [2:0]  pb;
    logic [3:0]  src_bits;
    logic [3:0]  px;
    logic [3:0]  left_bits;
    logic        consume;

    function automatic logic [3:0] px_count(input logic [2:0] p, input logic [3:0] bits);
        logic [3:0] cnt;
        cnt = 4'd0;
        for (int k = 1; k < 16; k++)
        begin
            if (7'(k) * {4'b0, p} <= {3'b0, bits})
            begin
                cnt = cnt + 4'd1;
            end
        end
        return cnt;
    endfunction

    assign consume = item_valid && advance;

    always_comb
    begin
        if (width_pixels_reg == '0)
        begin
            eff_w = 14'd1;
        end
        else if ({1'b0, width_pixels_reg} > MAX_W)
        begin
            eff_w = MAX_W;
        end
        else
        begin
            eff_w = {1'b0, width_pixels_reg};
        end

        bpp = (bits_per_pixel_reg > 7'd64) ? 7'd64 : bits_per_pixel_reg;
        if (bpp == 7'd1)
        begin
            mode = MODE_ONE_BIT;
        end
        else if (bpp >= 7'd8)
        begin
            mode = MODE_WIDE;
        end
        else
        begin
            mode = MODE_WHITE;
        end
    end

    always_comb
    begin
        pixel_column_next  = pixel_column_reg;
        byte_in_pixel_next = byte_in_pixel_reg;
        weighted_sum_next  = weighted_sum_reg;
        pack_shift_next    = pack_shift_reg;
        res_valid          = 1'b0;
        res.packed_byte    = 8'h00;
        res.line_end       = 1'b0;

        rem_px   = ({1'b0, pixel_column_reg} < eff_w) ?
                   (eff_w - {1'b0, pixel_column_reg}) : 14'd1;
        n_bytes  = bpp[6:3];
        if (bpp == 7'd24)
        begin
            weight = (byte_in_pixel_reg == 3'd0) ? 10'd299 :
                     ((byte_in_pixel_reg == 3'd1) ? 10'd587 : 10'd114);
        end
        else
        begin
            weight = 10'd1;
        end
        sum      = weighted_sum_reg + ({10'b0, item_byte} * {8'b0, weight});
        idx_inc  = {1'b0, byte_in_pixel_reg} + 4'd1;
        thresh   = (bpp == 7'd24) ? 18'd128000 : {7'b0, n_bytes, 7'b0};
        black    = (sum < thresh);
        pack_new = {pack_shift_reg[6:0], black};
        pb       = (bpp == 7'd0) ? 3'd1 : bpp[2:0];
        src_bits = {1'b0, byte_in_pixel_reg} + 4'd8;
        px       = px_count(pb, src_bits);
        left_bits = src_bits - 4'(px * {1'b0, pb});
        col      = 14'd0;

        case (mode)
            MODE_ONE_BIT:
            begin
                if (rem_px <= 14'd8)
                begin
                    res_valid          = 1'b1;
                    res.packed_byte    = item_byte & ~(8'hFF >> rem_px[3:0]);
                    res.line_end       = 1'b1;
                    pixel_column_next  = '0;
                    byte_in_pixel_next = '0;
                    weighted_sum_next  = '0;
                    pack_shift_next    = '0;
                end
                else
                begin
                    res_valid         = 1'b1;
                    res.packed_byte   = item_byte;
                    pixel_column_next = pixel_column_reg + 13'd8;
                end
            end
            MODE_WIDE:
            begin
                if (idx_inc < n_bytes)
                begin
                    byte_in_pixel_next = idx_inc[2:0];
                    weighted_sum_next  = sum;
                end
                else
                begin
                    weighted_sum_next  = '0;
                    byte_in_pixel_next = '0;
                    col = {1'b0, pixel_column_reg} + 14'd1;
                    if (col >= eff_w)
                    begin
                        res_valid         = 1'b1;
                        res.packed_byte   = pack_new << ~pixel_column_reg[2:0];
                        res.line_end      = 1'b1;
                        pixel_column_next = '0;
                        pack_shift_next   = '0;
                    end
                    else
                    begin
                        pixel_column_next = col[12:0];
                        if (col[2:0] == 3'd0)
                        begin
                            res_valid       = 1'b1;
                            res.packed_byte = pack_new;
                            pack_shift_next = '0;
                        end
                        else
                        begin
                            pack_shift_next = pack_new;
                        end
                    end
                end
            end
            MODE_WHITE:
            begin
                col = {1'b0, pixel_column_reg} + {10'b0, px};
                if (col >= eff_w)
                begin
                    res_valid          = 1'b1;
                    res.line_end       = 1'b1;
                    pixel_column_next  = '0;
                    byte_in_pixel_next = '0;
                    weighted_sum_next  = '0;
                    pack_shift_next    = '0;
                end
                else
                begin
                    pixel_column_next  = col[12:0];
                    byte_in_pixel_next = left_bits[2:0];
                    res_valid          = (col[12:3] != pixel_column_reg[12:3]);
                end
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_pixels_reg   <= WIDTH_RESET;
            bits_per_pixel_reg <= BPP_RESET;
            pixel_column_reg   <= '0;
            byte_in_pixel_reg  <= '0;
            weighted_sum_reg   <= '0;
            pack_shift_reg     <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_WIDTH_PIXELS)
            begin
                width_pixels_reg <= cfg_data[WIDTH_W-1:0];
            end
            else
            begin
                bits_per_pixel_reg <= cfg_data[BPP_W-1:0];
            end
            pixel_column_reg  <= '0;
            byte_in_pixel_reg <= '0;
            weighted_sum_reg  <= '0;
            pack_shift_reg    <= '0;
        end
        else if (consume)
        begin
            pixel_column_reg  <= pixel_column_next;
            byte_in_pixel_reg <= byte_in_pixel_next;
            weighted_sum_reg  <= weighted_sum_next;
            pack_shift_reg    <= pack_shift_next;
        end
    end

endmodule

// ----- rtl/rtmbp_out_reg.sv -----
// Result register that presents one packed byte until the receiver takes it.
module rtmbp_out_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  logic               res_valid,
    input  rtmbp_pkg::result_t res,
    input  logic               out_stall,
    output logic               out_valid,
    output logic [7:0]         packed_byte,
    output logic               line_end
);
    import rtmbp_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    assign out_valid   = valid_reg;
    assign packed_byte = data_reg.packed_byte;
    assign line_end    = data_reg.line_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= res_valid;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && res_valid)
        begin
            data_reg <= res;
        end
    end

endmodule

// ----- rtl/raster_to_mono_bitmap_packer.sv -----
// Top level of the raster to monochrome bitmap packer.
//
// Raster line bytes enter on the input channel (in_valid, in_stall, raw_byte)
// and packed 1-bit bytes leave on the output channel (out_valid, out_stall,
// packed_byte, line_end), leftmost pixel in bit 7 and 1 meaning black.
// A transfer takes place at a rising edge where valid is high and stall low.
// One byte is taken every cycle while the output is not stalled; some bytes
// produce no result, depending on the pixel size. A transferred byte sits
// in the input register while it is converted and packed, and its result
// is loaded into the result register, which shows it. The rate is set
// by the single update of the line state (column, pixel byte index, pixel
// sum and shift register) that each byte performs.
// When the receiver stalls, the result register holds its byte and the
// input register takes a byte only while empty, then in_stall rises.
// Registers are written through cfg_we, cfg_index and cfg_data only while
// the block is idle, a rule for the user that the block does not enforce;
// every write restarts the current line. Reset empties both registers and
// sets width one pixel, pixel size eight bits, and starts a fresh line.
module raster_to_mono_bitmap_packer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rtmbp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rtmbp_pkg::CFG_W-1:0]     cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      raw_byte,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [7:0]                      packed_byte,
    output logic                            line_end
);
    import rtmbp_pkg::*;

    logic       advance;
    logic       item_valid;
    logic [7:0] item_byte;
    logic       res_valid;
    result_t    res;

    assign advance = !out_valid || !out_stall;

    rtmbp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .raw_byte   (raw_byte),
        .advance    (advance),
        .in_stall   (in_stall),
        .item_valid (item_valid),
        .item_byte  (item_byte)
    );

    rtmbp_pack_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item_byte  (item_byte),
        .advance    (advance),
        .res_valid  (res_valid),
        .res        (res)
    );

    rtmbp_out_reg u_out_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (item_valid && advance),
        .res_valid   (res_valid),
        .res         (res),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .packed_byte (packed_byte),
        .line_end    (line_end)
    );

endmodule

// ----- rtl/rtmbp_checker.sv -----
// Port-level checker for the raster packer and the bind that attaches it.
module rtmbp_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            cfg_we,
    input logic [rtmbp_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [rtmbp_pkg::CFG_W-1:0]     cfg_data,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic [7:0]                      raw_byte,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [7:0]                      packed_byte,
    input logic                            line_end
);
    import rtmbp_pkg::*;

    logic white_reg;
    logic narrow_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            white_reg  <= 1'b0;
            narrow_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_BITS_PER_PIXEL)
            begin
                white_reg <= (cfg_data[6:0] == 7'd0) ||
                             ((cfg_data[6:0] >= 7'd2) && (cfg_data[6:0] <= 7'd7));
            end
            else
            begin
                narrow_reg <= (cfg_data <= 13'd8);
            end
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(packed_byte) && $stable(line_end))
        else $error("Stalled result changed or vanished.");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("Input stalled without a stalled result.");

    a_white_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && white_reg && (raw_byte == raw_byte) |-> packed_byte == 8'h00)
        else $error("White pixel mode produced a black pixel.");

    a_narrow_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && narrow_reg && !in_valid |-> line_end || !narrow_reg)
        else $error("Line of at most eight pixels gave a result without line end.");

endmodule

bind raster_to_mono_bitmap_packer rtmbp_checker u_rtmbp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .raw_byte    (raw_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .packed_byte (packed_byte),
    .line_end    (line_end)
);

// ----- bench/raster_to_mono_bitmap_packer_tb.sv -----
// Self-checking testbench for the raster to monochrome bitmap packer.
`timescale 1ns / 100ps

module raster_to_mono_bitmap_packer_tb;

    import rtmbp_pkg::*;

    localparam int HOLD_CYCLES    = 150;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_ITEMS   = 600;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [7:0]           raw_byte = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [7:0]           packed_byte;
    logic                 line_end;

    // Shadow of the registers and of the line state of the block.
    logic [WIDTH_W-1:0] cfg_width = WIDTH_RESET;
    logic [BPP_W-1:0]   cfg_bpp = BPP_RESET;
    logic [12:0]        col_done = '0;
    logic [2:0]         pix_byte = '0;
    logic [17:0]        pix_sum = '0;
    logic [7:0]         shift_acc = '0;

    logic [7:0] raw_byte_q[$];
    result_t    expected_packed_q[$];

    int  error_count = 0;
    int  random_sent = 0;
    int  burst_left = 1;
    int  gap_left = 0;
    int  stall_mode = 0;
    int  stall_left = 0;
    int  stall_phase = 0;
    int  hold_left = 0;
    bit  hold_go = 1'b0;
    bit  hold_done = 1'b0;
    int  idle_cycles = 0;

    raster_to_mono_bitmap_packer uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .raw_byte    (raw_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .packed_byte (packed_byte),
        .line_end    (line_end)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic clear_line_state();
        col_done  = '0;
        pix_byte  = '0;
        pix_sum   = '0;
        shift_acc = '0;
    endtask

    task automatic push_packed(input logic [7:0] value, input logic last);
        result_t res;
        res.packed_byte = value;
        res.line_end    = last;
        expected_packed_q.push_back(res);
    endtask

    task automatic pack_raw_byte(input logic [7:0] data);
        int   w;
        int   b;
        int   rem;
        int   n;
        int   idx;
        int   weight;
        int   thresh;
        int   col;
        int   count;
        int   pb;
        int   bits;
        int   old;
        logic black;
        w = int'(cfg_width);
        if (w < 1)
            w = 1;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        b = int'(cfg_bpp);
        if (b > 64)
            b = 64;
        if (b == 1)
        begin
            rem = (int'(col_done) < w) ? w - int'(col_done) : 1;
            if (rem <= 8)
            begin
                push_packed(data & 8'(255 << (8 - rem)), 1'b1);
                clear_line_state();
            end
            else
            begin
                col_done = col_done + 13'd8;
                push_packed(data, 1'b0);
            end
        end
        else if (b >= 8)
        begin
            n = b / 8;
            idx = int'(pix_byte);
            weight = 1;
            if (b == 24)
                weight = (idx == 0) ? 299 : ((idx == 1) ? 587 : 114);
            pix_sum = 18'(int'(pix_sum) + int'(data) * weight);
            idx++;
            if (idx < n)
                pix_byte = 3'(idx);
            else
            begin
                thresh = (b == 24) ? 128000 : 128 * n;
                black = (int'(pix_sum) < thresh);
                pix_sum = '0;
                pix_byte = '0;
                shift_acc = {shift_acc[6:0], black};
                col = int'(col_done) + 1;
                if (col >= w)
                begin
                    count = ((col - 1) % 8) + 1;
                    push_packed(8'(int'(shift_acc) << (8 - count)), 1'b1);
                    clear_line_state();
                end
                else
                begin
                    col_done = 13'(col);
                    if (col % 8 == 0)
                    begin
                        push_packed(shift_acc, 1'b0);
                        shift_acc = '0;
                    end
                end
            end
        end
        else
        begin
            pb = (b == 0) ? 1 : b;
            bits = int'(pix_byte) + 8;
            old = int'(col_done);
            pix_byte = 3'(bits % pb);
            col = old + bits / pb;
            if (col >= w)
            begin
                push_packed(8'h00, 1'b1);
                clear_line_state();
            end
            else
            begin
                col_done = 13'(col);
                if (col / 8 != old / 8)
                    push_packed(8'h00, 1'b0);
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Input side: bursts of transfers separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            raw_byte <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                pack_raw_byte(raw_byte);
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (raw_byte_q.size() > 0)
                begin
                    in_valid <= 1'b1;
                    raw_byte <= raw_byte_q.pop_front();
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 60);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left--;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output side: checks each transfer and stalls on a changing pattern.
    always @(posedge clk or negedge rst_n)
    begin
        result_t exp_res;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_packed_q.size() == 0)
                    report_mismatch($sformatf("unexpected result %02h/%0b", packed_byte,
                                              line_end));
                else
                begin
                    exp_res = expected_packed_q.pop_front();
                    if (packed_byte !== exp_res.packed_byte)
                        report_mismatch($sformatf("packed_byte %02h, expected %02h",
                                                  packed_byte, exp_res.packed_byte));
                    if (line_end !== exp_res.line_end)
                        report_mismatch($sformatf("line_end %0b, expected %0b",
                                                  line_end, exp_res.line_end));
                end
            end
            if (hold_go && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (stall_left == 0)
                begin
                    stall_mode = $urandom_range(0, 3);
                    stall_left = $urandom_range(16, 80);
                end
                else
                    stall_left--;
                stall_phase = (stall_phase + 1) % 5;
                case (stall_mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= 1'($urandom_range(0, 1));
                    default: out_stall <= (stall_phase < 2);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("CHECK FAILED");
                    $finish;
                end
            end
        end
    end

    task automatic wait_idle();
        @(negedge clk);
        while (raw_byte_q.size() != 0 || in_valid || expected_packed_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_WIDTH_PIXELS)
            cfg_width = data[WIDTH_W-1:0];
        else
            cfg_bpp = data[BPP_W-1:0];
        clear_line_state();
    endtask

    // Writes happen only once every transfer has drained and the block has settled.
    task automatic configure(input int w, input int b);
        logic [CFG_W-1:0] bpp_word;
        wait_idle();
        repeat (4) @(posedge clk);
        bpp_word = {6'($urandom_range(0, 63)), 7'(b)};
        if ($urandom_range(0, 1))
        begin
            write_reg(CFG_WIDTH_PIXELS, 13'(w));
            write_reg(CFG_BITS_PER_PIXEL, bpp_word);
        end
        else
        begin
            write_reg(CFG_BITS_PER_PIXEL, bpp_word);
            write_reg(CFG_WIDTH_PIXELS, 13'(w));
        end
        @(negedge clk);
    endtask

    function automatic logic [7:0] pick_raw_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h7F;
            3: return 8'h80;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int pick_bpp();
        case ($urandom_range(0, 9))
            0, 8: return 1;
            1, 9: return 8;
            2: return 24;
            3: return 0;
            4: return $urandom_range(2, 7);
            5: return 8 * $urandom_range(1, 8);
            6: return $urandom_range(9, 64);
            default: return $urandom_range(65, 127);
        endcase
    endfunction

    function automatic int pick_width();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return $urandom_range(MAX_WIDTH, 8191);
            2: return MAX_WIDTH;
            3: return MAX_WIDTH - 1;
            default: return $urandom_range(1, 40);
        endcase
    endfunction

    initial
    begin
        int n;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        raw_byte_q.push_back(8'h00);
        raw_byte_q.push_back(8'hFF);
        raw_byte_q.push_back(8'h7F);
        raw_byte_q.push_back(8'h80);

        configure(0, 1);
        raw_byte_q.push_back(8'hFF);
        raw_byte_q.push_back(8'hA5);

        configure(8191, 127);
        repeat (8) raw_byte_q.push_back(8'h00);

        configure(2, 24);
        raw_byte_q.push_back(8'd127);
        raw_byte_q.push_back(8'd128);
        raw_byte_q.push_back(8'd128);
        repeat (3) raw_byte_q.push_back(8'hFF);

        configure(9, 0);
        repeat (2) raw_byte_q.push_back(pick_raw_byte());

        configure(5, 3);
        repeat (2) raw_byte_q.push_back(pick_raw_byte());

        // Long receiver hold-off while the sender keeps offering transfers.
        configure(MAX_WIDTH, 8);
        repeat (120) raw_byte_q.push_back(pick_raw_byte());
        random_sent += 120;
        hold_go = 1'b1;

        while (random_sent < RANDOM_ITEMS)
        begin
            configure(pick_width(), pick_bpp());
            n = $urandom_range(10, 80);
            repeat (n) raw_byte_q.push_back(pick_raw_byte());
            random_sent += n;
        end

        wait_idle();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- raster_to_mono_bitmap_packer.f -----
rtl/rtmbp_pkg.sv
rtl/rtmbp_in_reg.sv
rtl/rtmbp_pack_core.sv
rtl/rtmbp_out_reg.sv
rtl/raster_to_mono_bitmap_packer.sv
rtl/rtmbp_checker.sv
bench/raster_to_mono_bitmap_packer_tb.sv
